[design/mark_list_text_parser_core_defines.svh]
// Assertion macros used by the mark list parser core
`ifndef MARK_LIST_TEXT_PARSER_CORE_DEFINES_SVH
`define MARK_LIST_TEXT_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MLP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mark list parser: assertion failed");

// Next-cycle implication, checked outside reset
`define MLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mark list parser: assertion failed");

`endif

[design/mlp_pkg.sv]
// Shared types and constants of the mark list parser
package mlp_pkg;

    localparam int MAX_KEY_DIGITS_DEF = 16;
    localparam int QUEUE_DEPTH        = 4;

    localparam logic [15:0] CH_COMMA = 16'h002C;
    localparam logic [15:0] CH_COLON = 16'h003A;

    // Character class of one queued word
    typedef enum logic [1:0] {
        TK_OTHER,
        TK_COMMA,
        TK_COLON,
        TK_EOT
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind   kind;
        logic        hex_ok;
        logic        dec_ok;
        logic [3:0]  digit;
    } t_tok;

    typedef enum logic [1:0] {
        RK_MARK,
        RK_ACCEPT,
        RK_REJECT
    } t_kind;

    typedef enum logic [1:0] {
        FLT_NONE,
        FLT_COLON,
        FLT_KEY,
        FLT_TYPE
    } t_fault;

    // Queue handshake between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[design/mlp_front.sv]
// Front end: accepts input words and classifies each character
module mlp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [15:0]   i_char_code,
    input  logic          i_end_of_text,
    input  logic          i_q_full,
    output logic          o_in_stall,
    output logic          o_push,
    output mlp_pkg::t_tok o_push_tok
);

    mlp_pkg::t_tok tok;
    logic          r_busy_seen;

    // Classify: separators, hex digit value, decimal digit flag
    always_comb begin
        tok        = '0;
        tok.kind   = mlp_pkg::TK_OTHER;
        if (i_end_of_text) begin
            tok.kind = mlp_pkg::TK_EOT;
        end else if (i_char_code == mlp_pkg::CH_COMMA) begin
            tok.kind = mlp_pkg::TK_COMMA;
        end else if (i_char_code == mlp_pkg::CH_COLON) begin
            tok.kind = mlp_pkg::TK_COLON;
        end
        if (!i_end_of_text) begin
            if (i_char_code >= 16'h0030 && i_char_code <= 16'h0039) begin
                tok.hex_ok = 1'b1;
                tok.dec_ok = 1'b1;
                tok.digit  = i_char_code[3:0];
            end else if (i_char_code >= 16'h0061 && i_char_code <= 16'h0066) begin
                tok.hex_ok = 1'b1;
                tok.digit  = 4'(i_char_code[3:0] + 4'd9);
            end else if (i_char_code >= 16'h0041 && i_char_code <= 16'h0046) begin
                tok.hex_ok = 1'b1;
                tok.digit  = 4'(i_char_code[3:0] + 4'd9);
            end
        end
    end

    // Track back pressure seen at the front (debug visibility only of stall)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_seen <= 1'b0;
        end else begin
            r_busy_seen <= i_in_valid && i_q_full;
        end
    end

    assign o_in_stall = i_q_full || (r_busy_seen && i_q_full);
    assign o_push     = i_in_valid && !i_q_full;
    assign o_push_tok = tok;

endmodule

[design/mlp_queue.sv]
// Short word queue between classifier and parser back end
module mlp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mlp_pkg::t_tok      i_push_tok,
    input  logic               i_pop,
    output mlp_pkg::t_tok      o_pop_tok,
    output mlp_pkg::t_q_status o_status
);

    localparam int DEPTH = mlp_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    mlp_pkg::t_tok r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_pop_tok      = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(r_rd_ptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_tok;
        end
    end

endmodule

[design/mlp_back.sv]
// Back end: item parser state, result register and pending verdict
module mlp_back #(
    parameter int MAX_KEY_DIGITS = mlp_pkg::MAX_KEY_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mlp_pkg::t_tok      i_tok,
    input  mlp_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_result_kind,
    output logic [62:0]        o_position,
    output logic [1:0]         o_mark_type,
    output logic [1:0]         o_fault,
    output logic               o_last_of_run
);

    localparam int KCW = $clog2(MAX_KEY_DIGITS + 2);

    typedef enum logic [1:0] {
        PH_KEY,
        PH_TYPE,
        PH_FAIL
    } t_phase;

    t_phase          r_phase,       n_phase;
    logic            r_item_seen,   n_item_seen;
    logic [63:0]     r_key_value,   n_key_value;
    logic [KCW-1:0]  r_key_cnt,     n_key_cnt;
    logic            r_key_bad,     n_key_bad;
    logic [2:0]      r_type_sat,    n_type_sat;
    logic            r_type_seen,   n_type_seen;
    logic            r_type_bad,    n_type_bad;
    mlp_pkg::t_fault r_first_fault, n_first_fault;

    logic            r_out_valid,   n_out_valid;
    mlp_pkg::t_kind  r_kind,        n_kind;
    logic [62:0]     r_pos,         n_pos;
    logic [1:0]      r_mtype,       n_mtype;
    mlp_pkg::t_fault r_fault,       n_fault;
    logic            r_last,        n_last;
    logic            r_pend,        n_pend;

    logic            out_free;
    logic            key_ok;
    logic            type_ok;
    logic            close_mark;
    mlp_pkg::t_fault close_fault;
    mlp_pkg::t_fault eot_fault;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = out_free && !r_pend && !i_q_status.empty;

    // Item checks at a closing comma or end marker
    assign key_ok  = !r_key_bad && (r_key_cnt != '0)
                     && (r_key_cnt <= KCW'(MAX_KEY_DIGITS)) && !r_key_value[63];
    assign type_ok = !r_type_bad && r_type_seen
                     && (r_type_sat >= 3'd1) && (r_type_sat <= 3'd3);

    always_comb begin
        close_mark  = 1'b0;
        close_fault = mlp_pkg::FLT_NONE;
        unique case (r_phase)
            PH_KEY: begin
                if (r_item_seen) begin
                    close_fault = mlp_pkg::FLT_COLON;
                end
            end
            PH_TYPE: begin
                if (!key_ok) begin
                    close_fault = mlp_pkg::FLT_KEY;
                end else if (!type_ok) begin
                    close_fault = mlp_pkg::FLT_TYPE;
                end else begin
                    close_mark = 1'b1;
                end
            end
            default: begin
                close_fault = mlp_pkg::FLT_NONE;
            end
        endcase
        eot_fault = (r_phase == PH_FAIL) ? r_first_fault : close_fault;
    end

    // Next state and result selection
    always_comb begin
        n_phase       = r_phase;
        n_item_seen   = r_item_seen;
        n_key_value   = r_key_value;
        n_key_cnt     = r_key_cnt;
        n_key_bad     = r_key_bad;
        n_type_sat    = r_type_sat;
        n_type_seen   = r_type_seen;
        n_type_bad    = r_type_bad;
        n_first_fault = r_first_fault;
        n_out_valid   = r_out_valid;
        n_kind        = r_kind;
        n_pos         = r_pos;
        n_mtype       = r_mtype;
        n_fault       = r_fault;
        n_last        = r_last;
        n_pend        = r_pend;

        if (out_free) begin
            n_out_valid = 1'b0;
        end

        if (out_free && r_pend) begin
            // Accept verdict that follows a mark on the same end marker
            n_out_valid = 1'b1;
            n_kind      = mlp_pkg::RK_ACCEPT;
            n_pos       = '0;
            n_mtype     = '0;
            n_fault     = mlp_pkg::FLT_NONE;
            n_last      = 1'b1;
            n_pend      = 1'b0;
        end else if (o_pop) begin
            if (i_tok.kind == mlp_pkg::TK_EOT) begin
                if (close_mark) begin
                    n_out_valid = 1'b1;
                    n_kind      = mlp_pkg::RK_MARK;
                    n_pos       = r_key_value[62:0];
                    n_mtype     = r_type_sat[1:0];
                    n_fault     = mlp_pkg::FLT_NONE;
                    n_last      = 1'b0;
                    n_pend      = 1'b1;
                end else begin
                    n_out_valid = 1'b1;
                    n_kind      = (eot_fault != mlp_pkg::FLT_NONE) ?
                                  mlp_pkg::RK_REJECT : mlp_pkg::RK_ACCEPT;
                    n_pos       = '0;
                    n_mtype     = '0;
                    n_fault     = eot_fault;
                    n_last      = 1'b1;
                end
                n_phase       = PH_KEY;
                n_first_fault = mlp_pkg::FLT_NONE;
                n_item_seen   = 1'b0;
                n_key_value   = '0;
                n_key_cnt     = '0;
                n_key_bad     = 1'b0;
                n_type_sat    = '0;
                n_type_seen   = 1'b0;
                n_type_bad    = 1'b0;
            end else if (r_phase == PH_FAIL) begin
                n_phase = PH_FAIL;
            end else if (i_tok.kind == mlp_pkg::TK_COMMA) begin
                if (close_mark) begin
                    n_out_valid = 1'b1;
                    n_kind      = mlp_pkg::RK_MARK;
                    n_pos       = r_key_value[62:0];
                    n_mtype     = r_type_sat[1:0];
                    n_fault     = mlp_pkg::FLT_NONE;
                    n_last      = 1'b1;
                end
                if (close_fault != mlp_pkg::FLT_NONE) begin
                    n_phase       = PH_FAIL;
                    n_first_fault = close_fault;
                end else begin
                    n_phase     = PH_KEY;
                    n_item_seen = 1'b0;
                    n_key_value = '0;
                    n_key_cnt   = '0;
                    n_key_bad   = 1'b0;
                    n_type_sat  = '0;
                    n_type_seen = 1'b0;
                    n_type_bad  = 1'b0;
                end
            end else begin
                n_item_seen = 1'b1;
                if (r_phase == PH_KEY) begin
                    if (i_tok.kind == mlp_pkg::TK_COLON) begin
                        n_phase = PH_TYPE;
                    end else if (!i_tok.hex_ok) begin
                        n_key_bad = 1'b1;
                    end else if (r_key_cnt < KCW'(MAX_KEY_DIGITS)) begin
                        n_key_value = {r_key_value[59:0], i_tok.digit};
                        n_key_cnt   = KCW'(r_key_cnt + 1'b1);
                    end else begin
                        n_key_cnt = KCW'(MAX_KEY_DIGITS + 1);
                    end
                end else begin
                    if (i_tok.dec_ok) begin
                        // Saturating decimal accumulate, ceiling four
                        if (r_type_sat != 3'd0 || i_tok.digit > 4'd4) begin
                            n_type_sat = 3'd4;
                        end else begin
                            n_type_sat = i_tok.digit[2:0];
                        end
                        n_type_seen = 1'b1;
                    end else begin
                        n_type_bad = 1'b1;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_KEY;
            r_item_seen   <= 1'b0;
            r_key_value   <= '0;
            r_key_cnt     <= '0;
            r_key_bad     <= 1'b0;
            r_type_sat    <= '0;
            r_type_seen   <= 1'b0;
            r_type_bad    <= 1'b0;
            r_first_fault <= mlp_pkg::FLT_NONE;
            r_out_valid   <= 1'b0;
            r_pend        <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_item_seen   <= n_item_seen;
            r_key_value   <= n_key_value;
            r_key_cnt     <= n_key_cnt;
            r_key_bad     <= n_key_bad;
            r_type_sat    <= n_type_sat;
            r_type_seen   <= n_type_seen;
            r_type_bad    <= n_type_bad;
            r_first_fault <= n_first_fault;
            r_out_valid   <= n_out_valid;
            r_pend        <= n_pend;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_pos   <= n_pos;
        r_mtype <= n_mtype;
        r_fault <= n_fault;
        r_last  <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_position    = r_pos;
    assign o_mark_type   = r_mtype;
    assign o_fault       = r_fault;
    assign o_last_of_run = r_last;

endmodule

[design/mark_list_text_parser_core.sv]
// A result word is registered in the back end after its input word leaves the queue storage.
// Throughput: one character word per cycle when neither side stalls, set by the single-word back end step;
// an end marker that closes a valid item emits two results, the mark and then the accept verdict.
// A four-word queue parts the classifier from the parser so each side stalls alone.
// Reset (i_rst_n low, synchronous) empties the queue and output and starts a new list.
`include "mark_list_text_parser_core_defines.svh"

module mark_list_text_parser_core #(
    parameter int MAX_KEY_DIGITS = mlp_pkg::MAX_KEY_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_char_code,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [62:0] o_position,
    output logic [1:0]  o_mark_type,
    output logic [1:0]  o_fault,
    output logic        o_last_of_run
);

    logic               push;
    mlp_pkg::t_tok      push_tok;
    logic               pop;
    mlp_pkg::t_tok      pop_tok;
    mlp_pkg::t_q_status q_status;

    mlp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (q_status.full),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_push_tok    (push_tok)
    );

    mlp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_tok (push_tok),
        .i_pop      (pop),
        .o_pop_tok  (pop_tok),
        .o_status   (q_status)
    );

    mlp_back #(
        .MAX_KEY_DIGITS (MAX_KEY_DIGITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tok         (pop_tok),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_position    (o_position),
        .o_mark_type   (o_mark_type),
        .o_fault       (o_fault),
        .o_last_of_run (o_last_of_run)
    );

    // A mark word carries a real type and no fault
    `MLP_ASSERT_IMPL(a_mark_fields, i_clk, i_rst_n, o_out_valid && o_result_kind == mlp_pkg::RK_MARK, o_mark_type != 2'd0 && o_fault == mlp_pkg::FLT_NONE)
    // A reject verdict always names its fault and closes the run
    `MLP_ASSERT_IMPL(a_reject_fault, i_clk, i_rst_n, o_out_valid && o_result_kind == mlp_pkg::RK_REJECT, o_fault != mlp_pkg::FLT_NONE && o_last_of_run && o_position == '0)
    // A mark that is not last of its run is followed by the accept verdict
    `MLP_ASSERT_NEXT(a_mark_then_verdict, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_result_kind == mlp_pkg::RK_MARK && !o_last_of_run, o_out_valid && o_result_kind == mlp_pkg::RK_ACCEPT)
    // The queue never pops while empty
    `MLP_ASSERT_IMPL(a_no_empty_pop, i_clk, i_rst_n, pop, !q_status.empty)

endmodule

[dv/mark_list_text_parser_checker.sv]
// Checker for the mark list parser: predicts results from accepted words and compares them
module mark_list_text_parser_checker
    import mlp_pkg::*;
#(
    parameter int MAX_KEY_DIGITS = MAX_KEY_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [15:0] i_char_code,
    input  logic        i_end_of_text,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_result_kind,
    input  logic [62:0] i_position,
    input  logic [1:0]  i_mark_type,
    input  logic [1:0]  i_fault,
    input  logic        i_last_of_run,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_mark_count,
    output int          o_accept_count,
    output int          o_reject_count
);

    localparam logic [63:0] SIGN_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [15:0] CH_0  = 16'h0030;
    localparam logic [15:0] CH_9  = 16'h0039;
    localparam logic [15:0] CH_LA = 16'h0061;
    localparam logic [15:0] CH_LF = 16'h0066;
    localparam logic [15:0] CH_UA = 16'h0041;
    localparam logic [15:0] CH_UF = 16'h0046;

    typedef enum logic [1:0] {
        PH_KEY,
        PH_TYPE,
        PH_FAIL
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [62:0] position;
        logic [1:0]  mark_type;
        t_fault      fault;
        logic        last;
    } t_result;

    // Parser state as seen from outside
    t_phase      phase;
    logic        item_seen;
    logic [63:0] key_value;
    logic [4:0]  key_digits;
    logic        key_bad;
    logic [2:0]  type_sat;
    logic        type_digit_seen;
    logic        type_bad;
    t_fault      first_fault;

    t_result results_due[$];

    int fail_count    = 0;
    int pending_count = 0;
    int mark_count    = 0;
    int accept_count  = 0;
    int reject_count  = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending_count;
    assign o_mark_count   = mark_count;
    assign o_accept_count = accept_count;
    assign o_reject_count = reject_count;

    function automatic int hex_value(input logic [15:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c) - int'(CH_0);
        if (c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
        return -1;
    endfunction

    task automatic clear_entry();
        item_seen       = 1'b0;
        key_value       = '0;
        key_digits      = '0;
        key_bad         = 1'b0;
        type_sat        = '0;
        type_digit_seen = 1'b0;
        type_bad        = 1'b0;
    endtask

    task automatic restart_list();
        phase       = PH_KEY;
        first_fault = FLT_NONE;
        clear_entry();
    endtask

    task automatic store_result(input t_kind kind, input logic [62:0] pos,
                                input logic [1:0] mtype, input t_fault flt,
                                input logic last);
        t_result r;
        r.kind      = kind;
        r.position  = pos;
        r.mark_type = mtype;
        r.fault     = flt;
        r.last      = last;
        results_due.push_back(r);
    endtask

    // Close the item at a comma or at the end marker
    task automatic close_entry(input logic last);
        case (phase)
            PH_KEY: begin
                if (item_seen) begin
                    first_fault = FLT_COLON;
                    phase       = PH_FAIL;
                end
            end
            PH_TYPE: begin
                if (key_bad || key_digits == 0 || key_digits > MAX_KEY_DIGITS ||
                    key_value > SIGN_LIMIT) begin
                    first_fault = FLT_KEY;
                    phase       = PH_FAIL;
                end else if (type_bad || !type_digit_seen || type_sat < 1 ||
                             type_sat > 3) begin
                    first_fault = FLT_TYPE;
                    phase       = PH_FAIL;
                end else begin
                    store_result(RK_MARK, key_value[62:0], type_sat[1:0], FLT_NONE, last);
                    phase = PH_KEY;
                end
            end
            default: ;
        endcase
        if (phase != PH_FAIL) clear_entry();
    endtask

    // One accepted input word
    task automatic parse_word(input logic [15:0] c, input logic eot);
        int digit;
        int sum;
        if (eot) begin
            if (phase != PH_FAIL) close_entry(1'b0);
            if (phase == PH_FAIL) store_result(RK_REJECT, '0, '0, first_fault, 1'b1);
            else store_result(RK_ACCEPT, '0, '0, FLT_NONE, 1'b1);
            restart_list();
        end else if (phase != PH_FAIL) begin
            if (c == CH_COMMA) begin
                close_entry(1'b1);
            end else begin
                item_seen = 1'b1;
                if (phase == PH_KEY) begin
                    if (c == CH_COLON) begin
                        phase = PH_TYPE;
                    end else begin
                        digit = hex_value(c);
                        if (digit < 0) begin
                            key_bad = 1'b1;
                        end else if (key_digits < MAX_KEY_DIGITS) begin
                            key_value  = {key_value[59:0], 4'(digit)};
                            key_digits = key_digits + 1'b1;
                        end else begin
                            key_digits = 5'(MAX_KEY_DIGITS + 1);
                        end
                    end
                end else if (c >= CH_0 && c <= CH_9) begin
                    // type value saturates at 4
                    sum             = int'(type_sat) * 10 + int'(c) - int'(CH_0);
                    type_sat        = (sum > 4) ? 3'd4 : 3'(sum);
                    type_digit_seen = 1'b1;
                end else begin
                    type_bad = 1'b1;
                end
            end
        end
    endtask

    // Compare one accepted result word with the oldest expectation
    task automatic check_result();
        t_result seen;
        t_result want;
        seen.kind      = t_kind'(i_result_kind);
        seen.position  = i_position;
        seen.mark_type = i_mark_type;
        seen.fault     = t_fault'(i_fault);
        seen.last      = i_last_of_run;
        case (seen.kind)
            RK_MARK:   mark_count++;
            RK_ACCEPT: accept_count++;
            default:   reject_count++;
        endcase
        if (results_due.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result: kind %0d pos %h type %0d fault %0d last %0b",
                         seen.kind, seen.position, seen.mark_type, seen.fault, seen.last);
        end else begin
            want = results_due.pop_front();
            if (seen.kind != want.kind || seen.position != want.position ||
                seen.mark_type != want.mark_type || seen.fault != want.fault ||
                seen.last != want.last) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("mismatch: expected kind %0d pos %h type %0d fault %0d last %0b",
                             want.kind, want.position, want.mark_type, want.fault, want.last);
                    $display("          actual   kind %0d pos %h type %0d fault %0d last %0b",
                             seen.kind, seen.position, seen.mark_type, seen.fault, seen.last);
                end
            end
        end
    endtask

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_list();
            results_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) parse_word(i_char_code, i_end_of_text);
            if (i_out_valid && !i_out_stall) check_result();
        end
        pending_count = results_due.size();
    end

endmodule

[dv/testbench.sv]
// Top of the mark list parser test: clock, reset, stimulus, output stalls and verdict
module testbench;
    import mlp_pkg::*;

    localparam int HOLD_CYCLES = 64;
    localparam logic [15:0] CH_0     = 16'h0030;
    localparam logic [15:0] CH_LA    = 16'h0061;
    localparam logic [15:0] CH_UA    = 16'h0041;
    localparam logic [15:0] CH_MINUS = 16'h002D;
    localparam logic [15:0] CH_PLUS  = 16'h002B;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [15:0] char_code = '0;
    logic        eot       = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [62:0] position;
    logic [1:0]  mark_type;
    logic [1:0]  fault;
    logic        last_of_run;

    int fail_count;
    int pending_count;
    int mark_count;
    int accept_count;
    int reject_count;

    bit sender_idle_on = 1'b1;
    bit sink_idle_on   = 1'b1;
    bit hold_req       = 1'b0;
    bit hold_served    = 1'b0;
    int words_sent     = 0;
    int lists_sent     = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    mark_list_text_parser_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_char_code   (char_code),
        .i_end_of_text (eot),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_result_kind (result_kind),
        .o_position    (position),
        .o_mark_type   (mark_type),
        .o_fault       (fault),
        .o_last_of_run (last_of_run)
    );

    mark_list_text_parser_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_char_code    (char_code),
        .i_end_of_text  (eot),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_result_kind  (result_kind),
        .i_position     (position),
        .i_mark_type    (mark_type),
        .i_fault        (fault),
        .i_last_of_run  (last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_mark_count   (mark_count),
        .o_accept_count (accept_count),
        .o_reject_count (reject_count)
    );

    function automatic logic [15:0] hex_char(input int d);
        if (d < 10) return CH_0 + 16'(d);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 16'(d - 10);
    endfunction

    // Offer one word from a falling edge and return at the falling edge after it is taken
    task automatic send_word(input logic [15:0] c, input logic end_mark);
        if (sender_idle_on && $urandom_range(0, 7) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid  = 1'b1;
        char_code = c;
        eot       = end_mark;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_word({8'h00, s[i]}, 1'b0);
    endtask

    task automatic send_key(input int digits, input int first_max);
        int j;
        for (j = 0; j < digits; j++)
            send_word(hex_char(j == 0 ? $urandom_range(0, first_max) : $urandom_range(0, 15)),
                      1'b0);
    endtask

    // Decimal type text, sometimes with leading zeros
    task automatic send_type(input int value);
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) send_word(CH_0, 1'b0);
        if (value >= 10) send_word(CH_0 + 16'(value / 10), 1'b0);
        send_word(CH_0 + 16'(value % 10), 1'b0);
    endtask

    task automatic send_good_entry();
        int digits;
        digits = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 16) : $urandom_range(1, 4);
        send_key(digits, digits == 16 ? 7 : 15);
        send_word(CH_COLON, 1'b0);
        send_type($urandom_range(1, 3));
    endtask

    // One faulty item of a random flavor
    task automatic send_broken_entry();
        case ($urandom_range(0, 7))
            0: send_key($urandom_range(1, 4), 15);
            1: begin
                send_key($urandom_range(0, 2), 15);
                send_word(16'($urandom_range(0, 65535)), 1'b0);
                send_key($urandom_range(0, 2), 15);
                send_word(CH_COLON, 1'b0);
                send_type(1);
            end
            2: begin
                send_word(CH_COLON, 1'b0);
                send_type($urandom_range(1, 3));
            end
            3: begin
                send_key($urandom_range(1, 3), 15);
                send_word(CH_COLON, 1'b0);
            end
            4: begin
                send_key($urandom_range(1, 3), 15);
                send_word(CH_COLON, 1'b0);
                send_type($urandom_range(0, 1) ? 0 : $urandom_range(4, 99));
            end
            5: begin
                send_key($urandom_range(1, 3), 15);
                send_word(CH_COLON, 1'b0);
                send_word($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, 1'b0);
                send_type($urandom_range(1, 3));
            end
            6: begin
                send_key($urandom_range(1, 3), 15);
                send_word(CH_COLON, 1'b0);
                if ($urandom_range(0, 1)) send_type($urandom_range(1, 3));
                send_word(CH_COLON, 1'b0);
                send_type($urandom_range(1, 3));
            end
            default: begin
                send_key($urandom_range(16, 18), 15);
                send_word(CH_COLON, 1'b0);
                send_type($urandom_range(1, 3));
            end
        endcase
    endtask

    // One list closed by the end marker; mostly well formed, some noise
    task automatic send_random_list();
        int entries;
        int i;
        int pick;
        entries = $urandom_range(0, 5);
        lists_sent++;
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 3))
                    0: send_word(CH_COMMA, 1'b0);
                    1: send_word(CH_COLON, 1'b0);
                    2: send_word(hex_char($urandom_range(0, 15)), 1'b0);
                    default: send_word(16'($urandom_range(0, 65535)), 1'b0);
                endcase
            end
        end else begin
            for (i = 0; i < entries; i++) begin
                if (i > 0) send_word(CH_COMMA, 1'b0);
                pick = $urandom_range(0, 99);
                if (pick < 78) send_good_entry();
                else if (pick >= 83) send_broken_entry();
            end
            if ($urandom_range(0, 3) == 0) send_word(CH_COMMA, 1'b0);
        end
        send_word(16'($urandom_range(0, 65535)), 1'b1);
    endtask

    // Output stall: random bursts, one long hold on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req && !hold_served) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_served = 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                out_stall = 1'b1;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    // Run limit
    initial begin
        #(8 * 400000);
        $display("FAILURE");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: two marks with an empty item, end marker closing a valid item
        send_string("aF:1,,0:3");
        send_word(16'hFFFF, 1'b1);
        // missing colon wins
        send_string("1,2");
        send_word(16'h0000, 1'b1);
        // bad key character at the top code
        send_word(16'hFFFF, 1'b0);
        send_string(":1");
        send_word(16'h0000, 1'b1);
        // signed type
        send_string("1:-");
        send_word(16'h0000, 1'b1);
        // second colon in the type
        send_string("1:1:");
        send_word(16'h0000, 1'b1);
        // empty list
        send_word(16'h0000, 1'b1);

        while (words_sent < 600) send_random_list();

        // long output hold while the sender keeps pushing
        sender_idle_on = 1'b0;
        hold_req       = 1'b1;
        repeat (24) begin
            send_key($urandom_range(1, 3), 15);
            send_word(CH_COLON, 1'b0);
            send_type($urandom_range(1, 3));
            send_word(CH_COMMA, 1'b0);
        end
        send_word(16'h0000, 1'b1);
        hold_req = 1'b0;

        // sender pause until the block has drained
        in_valid = 1'b0;
        while (pending_count != 0) @(negedge clk);
        sender_idle_on = 1'b1;

        while (words_sent < 850) send_random_list();

        // last stretch at full rate on both sides
        sender_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        while (words_sent < 1000) send_random_list();

        in_valid = 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display("Sent %0d words in %0d random lists plus directed and burst lists.",
                 words_sent, lists_sent);
        $display("Checked %0d marks, %0d accepted lists and %0d rejected lists.",
                 mark_count, accept_count, reject_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
